>>> rtl/wrs_pkg.sv
// Package for the windowed retransmit sender: widths, codes, enum types, the
// command code and the status struct that join the controller and the datapath.
// Depends on nothing.
package wrs_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int RETRY_W     = 3;
  localparam int RETRY_LIMIT = 5;
  localparam int SEQ_W       = 32;
  localparam int CFG_W       = 16;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_EXH  = 2'd2,
    REQ_NONE = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    ACT_NEW   = 2'd0,
    ACT_RETX  = 2'd1,
    ACT_GIVEUP = 2'd2,
    ACT_END   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CFG_WINDOW   = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_FILL = 2'd0,
    PH_ACK  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_SCAN,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_EXH,
    OP_ACK_CLEAR,
    OP_TICK_INC,
    OP_SEND,
    OP_SCAN_START,
    OP_SCAN_HIT,
    OP_SCAN_SKIP,
    OP_FINISH_END,
    OP_RESTART,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    req_e_t req;
    phase_t phase;
    logic   fill_full;
    logic   fill_due;
    logic   scan_done;
    logic   slot_hit;
    logic   any_live;
    logic   exhausted;
    logic   pend_valid;
    logic   out_free;
  } status_t;

endpackage

>>> rtl/wrs_req_if.sv
// Request channel of the windowed retransmit sender.
// Depends on nothing.
interface wrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] ack_seq;
  modport source (output valid, req_type, ack_seq, input ready);
  modport sink (input valid, req_type, ack_seq, output ready);
endinterface

>>> rtl/wrs_res_if.sv
// Result channel of the windowed retransmit sender.
// Depends on nothing.
interface wrs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] out_seq;
  logic [3:0]  out_slot;
  logic        out_last;
  modport source (output valid, action, out_seq, out_slot, out_last, input ready);
  modport sink (input valid, action, out_seq, out_slot, out_last, output ready);
endinterface

>>> rtl/wrs_ctrl.sv
// Controller of the windowed retransmit sender: sequences each request through
// the datapath. Depends on wrs_pkg.
module wrs_ctrl
  import wrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output op_t     op
);

  state_t state, state_next;
  logic   blocked;

  assign blocked = st.pend_valid && !st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (st.req)
          REQ_TICK: state_next = ST_TICK;
          REQ_ACK:  state_next = (st.phase == PH_ACK) ? ST_CHECK : ST_IDLE;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_TICK: begin
        priority if (st.phase == PH_ACK) state_next = ST_SCAN;
        else if (st.phase == PH_FILL && st.fill_full) state_next = ST_SCAN;
        else if (st.phase == PH_FILL && st.fill_due) state_next = ST_FLUSH;
        else state_next = ST_IDLE;
      end
      ST_SCAN: if (st.scan_done) state_next = ST_CHECK;
      ST_CHECK: begin
        priority if (st.any_live) state_next = ST_FLUSH;
        else if (!(st.exhausted && blocked)) state_next = ST_FLUSH;
      end
      ST_FLUSH: if (!st.pend_valid || st.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      ST_EXEC: begin
        unique case (st.req)
          REQ_TICK: op = OP_TICK_INC;
          REQ_ACK:  if (st.phase != PH_DONE) op = OP_ACK_CLEAR;
          REQ_EXH:  op = OP_EXH;
          default:  op = OP_NONE;
        endcase
      end
      ST_TICK: begin
        priority if (st.phase == PH_ACK) op = OP_SCAN_START;
        else if (st.phase == PH_FILL && st.fill_full) op = OP_SCAN_START;
        else if (st.phase == PH_FILL && st.fill_due) op = OP_SEND;
        else op = OP_NONE;
      end
      ST_SCAN: begin
        priority if (st.scan_done) op = OP_NONE;
        else if (!st.slot_hit) op = OP_SCAN_SKIP;
        else if (!blocked) op = OP_SCAN_HIT;
        else op = OP_NONE;
      end
      ST_CHECK: begin
        priority if (st.any_live) op = OP_NONE;
        else if (!st.exhausted) op = OP_RESTART;
        else if (!blocked) op = OP_FINISH_END;
        else op = OP_NONE;
      end
      ST_FLUSH: if (st.pend_valid && st.out_free) op = OP_FLUSH;
      default: op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/wrs_dpath.sv
// Datapath of the windowed retransmit sender: configuration, window slots,
// timers, pending result and output register. Depends on wrs_pkg.
module wrs_dpath
  import wrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        in_req_type,
  input  logic [SEQ_W-1:0]  in_ack_seq,
  input  op_t               op,
  output status_t           st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_action,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_last
);

  logic [4:0]  window_size;
  logic [9:0]  send_interval_ms;
  logic [15:0] timeout_ms;

  phase_t             phase;
  logic [SEQ_W-1:0]   next_seq;
  logic [CNT_W-1:0]   sent_count;
  logic [SEQ_W-1:0]   now_ms;
  logic [SEQ_W-1:0]   last_send_ms;
  logic               data_exhausted;
  logic [CNT_W-1:0]   idx;
  logic [MAX_WINDOW-1:0] slot_live;
  logic [RETRY_W-1:0] slot_retries [MAX_WINDOW];
  logic [SEQ_W-1:0]   slot_seq [MAX_WINDOW];
  logic [SEQ_W-1:0]   slot_time [MAX_WINDOW];

  req_e_t           req_q;
  logic [SEQ_W-1:0] ack_q;

  logic              pend_valid;
  act_t              pend_act;
  logic [SEQ_W-1:0]  pend_seq;
  logic [SLOT_W-1:0] pend_slot;

  logic [CNT_W-1:0]  eff_w;
  logic [SLOT_W-1:0] si;
  logic [SLOT_W-1:0] wi;
  logic [SEQ_W-1:0]  age;
  logic              give_up;
  logic              push_en;
  logic              load_out;
  logic              out_free;
  act_t              new_act;
  logic [SEQ_W-1:0]  new_seq;
  logic [SLOT_W-1:0] new_slot;

  always_comb begin
    if (window_size == '0) eff_w = CNT_W'(1);
    else if (window_size > 5'(MAX_WINDOW)) eff_w = CNT_W'(MAX_WINDOW);
    else eff_w = CNT_W'(window_size);
  end

  assign si       = idx[SLOT_W-1:0];
  assign wi       = sent_count[SLOT_W-1:0];
  assign age      = now_ms - slot_time[si];
  assign give_up  = slot_retries[si] >= RETRY_W'(RETRY_LIMIT);
  assign out_free = !out_valid || out_ready;

  assign st.req        = req_q;
  assign st.phase      = phase;
  assign st.fill_full  = sent_count >= eff_w;
  assign st.fill_due   = (now_ms - last_send_ms) >= SEQ_W'(send_interval_ms);
  assign st.scan_done  = idx == sent_count;
  assign st.slot_hit   = slot_live[si] && (age > SEQ_W'(timeout_ms));
  assign st.any_live   = |slot_live;
  assign st.exhausted  = data_exhausted;
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;

  always_comb begin
    push_en  = 1'b0;
    new_act  = ACT_NEW;
    new_seq  = next_seq;
    new_slot = wi;
    unique case (op)
      OP_SEND: push_en = 1'b1;
      OP_SCAN_HIT: begin
        push_en  = 1'b1;
        new_act  = give_up ? ACT_GIVEUP : ACT_RETX;
        new_seq  = slot_seq[si];
        new_slot = si;
      end
      OP_FINISH_END: begin
        push_en  = 1'b1;
        new_act  = ACT_END;
        new_seq  = '0;
        new_slot = '0;
      end
      default: push_en = 1'b0;
    endcase
  end

  assign load_out = (push_en && pend_valid) || (op == OP_FLUSH);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size      <= 5'd1;
      send_interval_ms <= 10'd1;
      timeout_ms       <= 16'd100;
      phase            <= PH_FILL;
      next_seq         <= SEQ_W'(1);
      sent_count       <= '0;
      now_ms           <= '0;
      last_send_ms     <= '0;
      data_exhausted   <= 1'b0;
      idx              <= '0;
      slot_live        <= '0;
      for (int k = 0; k < MAX_WINDOW; k++) slot_retries[k] <= '0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW:   window_size      <= cfg_data[4:0];
          CFG_INTERVAL: send_interval_ms <= cfg_data[9:0];
          CFG_TIMEOUT:  timeout_ms       <= cfg_data;
          default:      ;
        endcase
      end
      unique case (op)
        OP_EXH: if (phase != PH_DONE) data_exhausted <= 1'b1;
        OP_ACK_CLEAR: begin
          for (int k = 0; k < MAX_WINDOW; k++) begin
            if (slot_live[k] && slot_seq[k] == ack_q) slot_live[k] <= 1'b0;
          end
        end
        OP_TICK_INC: now_ms <= now_ms + SEQ_W'(1);
        OP_SEND: begin
          slot_live[wi]    <= 1'b1;
          slot_retries[wi] <= '0;
          next_seq         <= next_seq + SEQ_W'(1);
          sent_count       <= sent_count + CNT_W'(1);
          last_send_ms     <= now_ms;
          if (sent_count + CNT_W'(1) >= eff_w) phase <= PH_ACK;
        end
        OP_SCAN_START: begin
          phase <= PH_ACK;
          idx   <= '0;
        end
        OP_SCAN_HIT: begin
          if (give_up) slot_live[si] <= 1'b0;
          else slot_retries[si] <= slot_retries[si] + RETRY_W'(1);
          idx <= idx + CNT_W'(1);
        end
        OP_SCAN_SKIP: idx <= idx + CNT_W'(1);
        OP_FINISH_END: phase <= PH_DONE;
        OP_RESTART: begin
          for (int k = 0; k < MAX_WINDOW; k++) slot_retries[k] <= '0;
          sent_count   <= '0;
          last_send_ms <= now_ms;
          phase        <= PH_FILL;
        end
        default: ;
      endcase
      if (push_en) pend_valid <= 1'b1;
      else if (op == OP_FLUSH) pend_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op == OP_LATCH) begin
      req_q <= req_e_t'(in_req_type);
      ack_q <= in_ack_seq;
    end
    if (op == OP_SEND) begin
      slot_seq[wi]  <= next_seq;
      slot_time[wi] <= now_ms;
    end
    if (op == OP_SCAN_HIT && !give_up) slot_time[si] <= now_ms;
    if (load_out) begin
      out_action <= pend_act;
      out_seq    <= pend_seq;
      out_slot   <= pend_slot;
      out_last   <= (op == OP_FLUSH);
    end
    if (push_en) begin
      pend_act  <= new_act;
      pend_seq  <= new_seq;
      pend_slot <= new_slot;
    end
  end

endmodule

>>> rtl/windowed_retransmit_sender.sv
// Windowed retransmit sender: one request at a time, taken in the idle state.
// A tick in the acking phase scans the window one slot per cycle, except that a
// timed-out slot waits while the pending result cannot move to the output register.
// Results leave through a one-deep pending register and an output register.
// Reset (rst, synchronous, active high) clears control state and loads the
// configuration defaults; slot sequence numbers and send times are left as is.
module windowed_retransmit_sender
  import wrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  wrs_req_if.sink          req,
  wrs_res_if.source        res,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // The controller and the datapath exchange only the operation code for the
  // current cycle and a status struct of decisions taken from datapath state.
  op_t     op;
  status_t st;

  // The controller takes a request only in its idle state; a finished result
  // may still wait in the output register while the next request is taken.
  wrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .op       (op)
  );

  // The datapath holds the window, the timers and the result registers. The
  // last result of each request is marked when the pending result is flushed.
  wrs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_req_type (req.req_type),
    .in_ack_seq  (req.ack_seq),
    .op          (op),
    .st          (st),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_action  (res.action),
    .out_seq     (res.out_seq),
    .out_slot    (res.out_slot),
    .out_last    (res.out_last)
  );

endmodule
